// ===== rtl/core/failure_backoff_table_unit_macros.svh =====
// assertion macros for the failure backoff table unit
`ifndef FAILURE_BACKOFF_TABLE_UNIT_MACROS_SVH
`define FAILURE_BACKOFF_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked while out of reset
`define FBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define FBT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define FBT_ASSERT(lbl, prop, msg)
`define FBT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/fbt_pkg.sv =====
// shared constants and types of the failure backoff table unit
package fbt_pkg;

  localparam int unsigned Slots     = 64;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned CntW      = $clog2(Slots + 1);
  localparam int unsigned SlotOutW  = 6;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned NowW      = 32;
  localparam int unsigned DeadlineW = 33;
  localparam int unsigned RetryW    = 4;
  localparam int unsigned CauseW    = 3;
  localparam int unsigned CoolW     = 16;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [KindW-1:0] KindCheck  = 2'd0;
  localparam logic [KindW-1:0] KindRecord = 2'd1;
  localparam logic [KindW-1:0] KindClear  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgRetryBudget  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgShortCooldown = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongCooldown  = 2'd2;

  localparam logic [RetryW-1:0] RetryBudgetRst   = 4'd2;
  localparam logic [CoolW-1:0]  ShortCooldownRst = 16'd10;
  localparam logic [CoolW-1:0]  LongCooldownRst  = 16'd120;

  typedef struct packed {
    logic [KeyW-1:0]      key;
    logic [DeadlineW-1:0] deadline;
    logic [RetryW-1:0]    retries;
    logic [CauseW-1:0]    cause;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic             start;
    logic             en;
    logic [SlotW-1:0] idx;
  } cmp_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    entry_t           hit_rec;
    logic             free_any;
    logic [SlotW-1:0] free_slot;
  } match_res_t;

endpackage

// ===== rtl/core/failure_backoff_table_unit.sv =====
// top level of the failure backoff table: sequencer, entry store and result register
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    kind_i key_i now_i failure_class_i
//   out      source     out_valid_o / out_stall_i  skip_o found_o slot_o budget_left_o
//   cfg      sink       cfg_we_i                   cfg_idx_i cfg_data_i
//
// each item sweeps the entry memory through its single read port, one entry a cycle, and
// the next item is taken only after the result of the one before is registered
// in_stall_o is low only while the sequencer is idle; a result held by out_stall_i
// delays the final write-back of the next item but not its acceptance
// reset clears the valid flags, the victim cursor and the registers to their
// reset values at once; no clearing pass is needed
`include "failure_backoff_table_unit_macros.svh"

module failure_backoff_table_unit import fbt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [KeyW-1:0]     key_i,
  input  logic [NowW-1:0]     now_i,
  input  logic [CauseW-1:0]   failure_class_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                skip_o,
  output logic                found_o,
  output logic [SlotOutW-1:0] slot_o,
  output logic [RetryW-1:0]   budget_left_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StUpdate = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [RetryW-1:0] budget_q;
  logic [CoolW-1:0]  short_cool_q;
  logic [CoolW-1:0]  long_cool_q;

  logic [KindW-1:0]  kind_q;
  logic [KeyW-1:0]   key_q;
  logic [NowW-1:0]   now_q;
  logic [CauseW-1:0] cause_q;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              cmp_en_q;
  logic [SlotW-1:0]  cmp_idx_q;
  logic [Slots-1:0]  valid_q;
  logic [SlotW-1:0]  cursor_q;

  logic              out_valid_q;
  logic              skip_q, found_q;
  logic [SlotW-1:0]  slot_q;
  logic [RetryW-1:0] left_q;

  logic              accept;
  logic              out_free;
  logic              commit;
  logic              rd_en;
  logic [EntryW-1:0] rd_raw;
  entry_t            rd_rec;
  cmp_ctl_t          cmp_ctl;
  match_res_t        res;

  logic              wr_en;
  logic [SlotW-1:0]  wr_addr;
  entry_t            wr_rec;
  logic              set_valid, clr_valid, cur_adv;
  logic [RetryW-1:0] base_r, new_r;
  logic [CoolW-1:0]  cool;
  logic              r_skip, r_found;
  logic [SlotW-1:0]  r_slot;
  logic [RetryW-1:0] r_left;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == StUpdate) && out_free;
  assign rd_en      = (state_q == StScan) && (cnt_q < CntW'(Slots));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q     <= RetryBudgetRst;
      short_cool_q <= ShortCooldownRst;
      long_cool_q  <= LongCooldownRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRetryBudget:   budget_q     <= cfg_data_i[RetryW-1:0];
        CfgShortCooldown: short_cool_q <= cfg_data_i[CoolW-1:0];
        CfgLongCooldown:  long_cool_q  <= cfg_data_i[CoolW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (cnt_q < CntW'(Slots)) begin
          cnt_d = cnt_q + CntW'(1);
        end else begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      cmp_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cmp_en_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cnt_q[SlotW-1:0];
    if (accept) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      now_q   <= now_i;
      cause_q <= failure_class_i;
    end
  end

  fbt_ram #(
    .Width (EntryW),
    .Depth (Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && commit),
    .waddr_i (wr_addr),
    .wdata_i (wr_rec),
    .re_i    (rd_en),
    .raddr_i (cnt_q[SlotW-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_rec        = entry_t'(rd_raw);
  assign cmp_ctl.start = accept;
  assign cmp_ctl.en    = cmp_en_q;
  assign cmp_ctl.idx   = cmp_idx_q;

  fbt_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (cmp_ctl),
    .key_i      (key_q),
    .rd_rec_i   (rd_rec),
    .rd_valid_i (valid_q[cmp_idx_q]),
    .res_o      (res)
  );

  // retry spend and cooldown for a record
  always_comb begin
    if (res.hit) begin
      base_r = res.hit_rec.retries;
    end else begin
      base_r = budget_q;
    end
    new_r = (base_r != '0) ? (base_r - RetryW'(1)) : '0;
    cool  = (new_r == '0) ? long_cool_q : short_cool_q;
  end

  // update of the addressed entry
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = res.hit_slot;
    wr_rec    = res.hit_rec;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    cur_adv   = 1'b0;
    r_skip    = 1'b0;
    r_found   = 1'b0;
    r_slot    = '0;
    r_left    = '0;
    case (kind_q)
      KindCheck: begin
        if (res.hit) begin
          r_found = 1'b1;
          r_slot  = res.hit_slot;
          r_left  = res.hit_rec.retries;
          if ({1'b0, now_q} < res.hit_rec.deadline) begin
            r_skip = 1'b1;
          end else if (res.hit_rec.retries == '0) begin
            wr_en          = 1'b1;
            wr_rec.retries = budget_q;
            r_left         = budget_q;
          end
        end
      end
      KindRecord: begin
        r_found = res.hit;
        if (res.hit) begin
          wr_addr = res.hit_slot;
        end else if (res.free_any) begin
          wr_addr = res.free_slot;
        end else begin
          wr_addr = cursor_q;
          cur_adv = 1'b1;
        end
        wr_en           = 1'b1;
        set_valid       = 1'b1;
        wr_rec.key      = key_q;
        wr_rec.deadline = {1'b0, now_q} + DeadlineW'(cool);
        wr_rec.retries  = new_r;
        wr_rec.cause    = cause_q;
        r_slot          = wr_addr;
        r_left          = new_r;
      end
      KindClear: begin
        if (res.hit) begin
          r_found   = 1'b1;
          r_slot    = res.hit_slot;
          clr_valid = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        if (set_valid) begin
          valid_q[wr_addr] <= 1'b1;
        end
        if (clr_valid) begin
          valid_q[res.hit_slot] <= 1'b0;
        end
        if (cur_adv) begin
          cursor_q <= (cursor_q == SlotW'(Slots - 1)) ? '0 : cursor_q + SlotW'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      skip_q  <= r_skip;
      found_q <= r_found;
      slot_q  <= r_slot;
      left_q  <= r_left;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign skip_o        = skip_q;
  assign found_o       = found_q;
  assign slot_o        = SlotOutW'(slot_q);
  assign budget_left_o = left_q;

  `FBT_ASSERT(a_result_from_update, $rose(out_valid_q) |-> $past(state_q == StUpdate), "result without update")
  `FBT_ASSERT(a_scan_bound, (state_q == StScan) |-> (cnt_q <= CntW'(Slots)), "scan counter overrun")
  `FBT_ASSERT(a_hit_is_valid, (state_q == StUpdate && res.hit) |-> valid_q[res.hit_slot], "hit on a free slot")
  `FBT_ASSERT(a_free_is_free, (state_q == StUpdate && res.free_any) |-> !valid_q[res.free_slot], "free slot in use")
  `FBT_ASSERT_RST(a_reset_no_result, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

// ===== rtl/core/fbt_ram.sv =====
// generic single-port-write, registered-read ram
module fbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fbt_match.sv =====
// key compare unit, one entry per cycle while enabled, tracks first hit and first free slot
module fbt_match import fbt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmp_ctl_t        ctl_i,
  input  logic [KeyW-1:0] key_i,
  input  entry_t          rd_rec_i,
  input  logic            rd_valid_i,
  output match_res_t      res_o
);

  logic             hit_q;
  logic [SlotW-1:0] hit_slot_q;
  entry_t           hit_rec_q;
  logic             free_any_q;
  logic [SlotW-1:0] free_slot_q;
  logic             is_hit;

  assign is_hit = ctl_i.en && rd_valid_i && (rd_rec_i.key == key_i) && !hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_any_q <= 1'b0;
    end else if (ctl_i.start) begin
      hit_q      <= 1'b0;
      free_any_q <= 1'b0;
    end else if (ctl_i.en) begin
      if (is_hit) begin
        hit_q <= 1'b1;
      end
      if (!rd_valid_i && !free_any_q) begin
        free_any_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_hit) begin
      hit_slot_q <= ctl_i.idx;
      hit_rec_q  <= rd_rec_i;
    end
    if (ctl_i.en && !ctl_i.start && !rd_valid_i && !free_any_q) begin
      free_slot_q <= ctl_i.idx;
    end
  end

  assign res_o.hit       = hit_q;
  assign res_o.hit_slot  = hit_slot_q;
  assign res_o.hit_rec   = hit_rec_q;
  assign res_o.free_any  = free_any_q;
  assign res_o.free_slot = free_slot_q;

endmodule
